/* src/mdps_pkg.sv */
`default_nettype none

package mdps_pkg;

    localparam int CELL_W     = 16;
    localparam int SUM_W      = 22;
    localparam int SIZE_W     = 7;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef logic signed [CELL_W-1:0] cell_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Position of a cell within its matrix, worked out when the item is taken.
    typedef struct packed {
        logic has_left;
        logic first_row;
        logic last_row;
        logic last_col;
    } cell_pos_t;

endpackage

`default_nettype wire

/* src/mdps_row_mem.sv */
`default_nettype none

module mdps_row_mem
    import mdps_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          aclk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire sum_t          wr_data,
    output sum_t               rd_data_a,
    output sum_t               rd_data_b
);

    sum_t mem [DEPTH];

    sum_t ram_a_reg;
    sum_t ram_b_reg;
    sum_t byp_data_reg;
    logic byp_a_reg;
    logic byp_b_reg;

    // A read that meets the write of the same entry in one cycle takes the
    // new data from the bypass register rather than the stale array word.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            ram_a_reg    <= mem[rd_addr_a];
            ram_b_reg    <= mem[rd_addr_b];
            byp_a_reg    <= wr_en && (wr_addr == rd_addr_a);
            byp_b_reg    <= wr_en && (wr_addr == rd_addr_b);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data_a = byp_a_reg ? byp_data_reg : ram_a_reg;
    assign rd_data_b = byp_b_reg ? byp_data_reg : ram_b_reg;

endmodule

`default_nettype wire

/* src/mdps_update.sv */
`default_nettype none

module mdps_update
    import mdps_pkg::*;
#(
    parameter int AW = 6
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          restart,
    input  wire logic          in_accept,
    input  wire cell_t         in_value,
    input  wire logic [AW-1:0] in_col,
    input  wire cell_pos_t     in_pos,
    output logic               in_ready,
    input  wire sum_t          here_data,
    input  wire sum_t          right_data,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output sum_t               wr_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sum_t               out_sum
);

    logic          b_valid_reg;
    cell_t         b_value_reg;
    logic [AW-1:0] b_col_reg;
    cell_pos_t     b_pos_reg;
    sum_t          left_prev_reg;
    sum_t          bottom_max_reg;
    logic          out_valid_reg;
    sum_t          out_sum_reg;

    sum_t value_ext;
    sum_t pick;
    sum_t best;
    sum_t bottom_next;
    logic emit;
    logic blocked;
    logic advance;

    always_comb begin
        value_ext = {{(SUM_W-CELL_W){b_value_reg[CELL_W-1]}}, b_value_reg};
        if (!b_pos_reg.has_left) begin
            pick = right_data;
        end else if (b_pos_reg.last_col) begin
            pick = left_prev_reg;
        end else begin
            pick = (left_prev_reg > right_data) ? left_prev_reg : right_data;
        end
        best = b_pos_reg.first_row ? value_ext : value_ext + pick;
        if (b_pos_reg.last_row && (best > bottom_max_reg)) begin
            bottom_next = best;
        end else begin
            bottom_next = bottom_max_reg;
        end
        emit    = b_valid_reg && b_pos_reg.last_row && b_pos_reg.last_col;
        // The stage waits only when a result is due and the previous one
        // has not yet been taken.
        blocked = emit && out_valid_reg && !out_ready;
        advance = b_valid_reg && !blocked;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_prev_reg  <= '0;
            bottom_max_reg <= SUM_MIN;
        end else begin
            if (in_accept) begin
                b_valid_reg <= 1'b1;
            end else if (advance) begin
                b_valid_reg <= 1'b0;
            end
            if (restart) begin
                left_prev_reg  <= '0;
                bottom_max_reg <= SUM_MIN;
            end else if (advance) begin
                left_prev_reg  <= here_data;
                bottom_max_reg <= emit ? SUM_MIN : bottom_next;
            end
            if (advance && emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            b_value_reg <= in_value;
            b_col_reg   <= in_col;
            b_pos_reg   <= in_pos;
        end
        if (advance && emit) begin
            out_sum_reg <= bottom_next;
        end
    end

    assign in_ready  = !blocked;
    assign wr_en     = advance;
    assign wr_addr   = b_col_reg;
    assign wr_data   = best;
    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

endmodule

`default_nettype wire

/* src/max_diagonal_path_sum.sv */
`default_nettype none

// Largest top-to-bottom diagonal path sum of a square signed matrix whose cells
// arrive in row-major order, one cell per item on the s_ channel. The block
// takes one cell every clock cycle; its only storage for the matrix is one row
// of best sums in a MAX_N-entry memory that each cell reads (two ports) as it
// is taken and writes back from its update stage, with a bypass for a read
// that meets that write. The result for a matrix is registered onto m_ after
// its last cell is taken, later while the previous result is held there. The
// input stalls only while a result is held by the m_ side and the next one is
// already due. The memory needs no clearing after reset,
// because row 0 writes every entry before any later row reads it. A write on
// the cfg_ channel sets the size (0 is taken as 1, sizes above MAX_N as MAX_N)
// and starts a new matrix; it must come while the block is idle.
module max_diagonal_path_sum
    import mdps_pkg::*;
#(
    parameter int MAX_N = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [SIZE_W-1:0]     cfg_data,     // matrix_size
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,      // [15:0] cell_value
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata       // [21:0] max_sum, zero above
);

    localparam int CW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int NW = $clog2(MAX_N + 1);
    localparam int RESET_N = (MAX_N < 4) ? MAX_N : 4;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_reg;
    logic [NW-1:0] size_reg;
    logic [NW-1:0] size_next;

    logic          s_accept;
    logic          cfg_accept;
    cell_pos_t     pos;
    logic [CW-1:0] right_addr;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    sum_t          wr_data;
    sum_t          here_data;
    sum_t          right_data;
    sum_t          out_sum;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_accept   = s_tvalid && s_tready;

    always_comb begin
        if (cfg_data == '0) begin
            size_next = NW'(1);
        end else if (32'(cfg_data) > MAX_N) begin
            size_next = NW'(MAX_N);
        end else begin
            size_next = NW'(cfg_data);
        end
        pos.has_left  = (col_reg != '0);
        pos.first_row = (row_reg == '0);
        pos.last_col  = ((NW'(col_reg) + NW'(1)) >= size_reg);
        pos.last_row  = ((NW'(row_reg) + NW'(1)) >= size_reg);
        right_addr    = pos.last_col ? col_reg : col_reg + CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            size_reg <= NW'(RESET_N);
        end else if (cfg_accept) begin
            col_reg  <= '0;
            row_reg  <= '0;
            size_reg <= size_next;
        end else if (s_accept) begin
            if (pos.last_col) begin
                col_reg <= '0;
                row_reg <= pos.last_row ? '0 : row_reg + CW'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    mdps_row_mem #(
        .DEPTH (MAX_N),
        .AW    (CW)
    ) u_row_mem (
        .aclk      (aclk),
        .rd_en     (s_accept),
        .rd_addr_a (col_reg),
        .rd_addr_b (right_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_data_a (here_data),
        .rd_data_b (right_data)
    );

    mdps_update #(
        .AW (CW)
    ) u_update (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (cfg_accept),
        .in_accept  (s_accept),
        .in_value   (cell_t'(s_tdata[CELL_W-1:0])),
        .in_col     (col_reg),
        .in_pos     (pos),
        .in_ready   (s_tready),
        .here_data  (here_data),
        .right_data (right_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sum    (out_sum)
    );

    assign m_tdata = {{(OUT_DATA_W-SUM_W){1'b0}}, out_sum};

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (NW'(col_reg) < size_reg) && (NW'(row_reg) < size_reg))
        else $error("cell position outside the matrix");

    a_size_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (size_reg != '0) && (size_reg <= NW'(MAX_N)))
        else $error("matrix size out of range");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_accept |=> (col_reg == '0) && (row_reg == '0))
        else $error("configuration write did not restart the matrix");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire

/* tb/max_diagonal_path_sum_tb.sv */
`timescale 1ns / 100ps

module max_diagonal_path_sum_tb;
    import mdps_pkg::*;

    localparam int N_LIMIT     = 64;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef enum logic {OP_SIZE, OP_CELL} script_op_e;

    typedef struct packed {
        script_op_e  op;
        logic [15:0] arg;
        logic        typed;
        sum_t        want;
    } script_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [SIZE_W-1:0]     cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_ready;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predictor state: one row of best sums and the position in the matrix.
    sum_t        best_row [N_LIMIT];
    sum_t        left_prev;
    sum_t        bottom_max;
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned n_eff;

    sum_t max_sum_q [$];
    int   fails      = 0;
    int   burst_left = 0;
    int   idle_count = 0;
    bit   hold_req   = 1'b0;

    // Directed items, walked in order straight after reset (size 4).
    script_row_t script [28] = '{
        '{OP_CELL, 16'h8000, 1'b0, '0}, '{OP_CELL, 16'h8000, 1'b0, '0},
        '{OP_CELL, 16'h8000, 1'b0, '0}, '{OP_CELL, 16'h8000, 1'b0, '0},
        '{OP_CELL, 16'h8000, 1'b0, '0}, '{OP_CELL, 16'h8000, 1'b0, '0},
        '{OP_CELL, 16'h8000, 1'b0, '0}, '{OP_CELL, 16'h8000, 1'b0, '0},
        '{OP_CELL, 16'h8000, 1'b0, '0}, '{OP_CELL, 16'h8000, 1'b0, '0},
        '{OP_CELL, 16'h8000, 1'b0, '0}, '{OP_CELL, 16'h8000, 1'b0, '0},
        '{OP_CELL, 16'h8000, 1'b0, '0}, '{OP_CELL, 16'h8000, 1'b0, '0},
        '{OP_CELL, 16'h8000, 1'b0, '0},
        '{OP_CELL, 16'h8000, 1'b1, sum_t'(-4 * 32768)},
        '{OP_SIZE, 16'd1,    1'b0, '0},
        '{OP_CELL, 16'h7FFF, 1'b1, sum_t'(32767)},
        '{OP_CELL, 16'h8000, 1'b1, sum_t'(-32768)},
        '{OP_SIZE, 16'd0,    1'b0, '0},
        '{OP_CELL, 16'h0001, 1'b1, sum_t'(1)},
        '{OP_SIZE, 16'd2,    1'b0, '0},
        '{OP_CELL, 16'h0005, 1'b0, '0},
        '{OP_SIZE, 16'd2,    1'b0, '0},
        '{OP_CELL, 16'h0005, 1'b0, '0},
        '{OP_CELL, 16'hFFFD, 1'b0, '0},
        '{OP_CELL, 16'h0007, 1'b0, '0},
        '{OP_CELL, 16'h0002, 1'b0, '0}
    };

    max_diagonal_path_sum #(
        .MAX_N(N_LIMIT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic void set_matrix_size(input logic [SIZE_W-1:0] sz);
        if (sz == 0)
            n_eff = 1;
        else if (sz > N_LIMIT)
            n_eff = N_LIMIT;
        else
            n_eff = 32'(sz);
        left_prev  = '0;
        col_pos    = 0;
        row_pos    = 0;
        bottom_max = SUM_MIN;
    endfunction

    // Takes one cell; returns 1 with the matrix maximum after its last cell.
    function automatic bit take_cell(input cell_t v, output sum_t res);
        int unsigned c;
        sum_t        here;
        sum_t        pick;
        sum_t        best;
        bit          last_row;
        c = (col_pos >= n_eff) ? 0 : col_pos;
        here = best_row[c];
        if (row_pos == 0) begin
            best = sum_t'(v);
        end else begin
            if (c > 0 && c + 1 < n_eff)
                pick = (left_prev > best_row[c+1]) ? left_prev : best_row[c+1];
            else if (c > 0)
                pick = left_prev;
            else
                pick = best_row[c+1];
            best = sum_t'(v) + pick;
        end
        left_prev   = here;
        best_row[c] = best;
        last_row = (row_pos + 1 >= n_eff);
        if (last_row && best > bottom_max)
            bottom_max = best;
        res = bottom_max;
        take_cell = 1'b0;
        if (c + 1 >= n_eff) begin
            col_pos   = 0;
            left_prev = '0;
            if (last_row) begin
                take_cell = 1'b1;
                set_matrix_size(SIZE_W'(n_eff));
            end else begin
                row_pos++;
            end
        end else begin
            col_pos = c + 1;
        end
    endfunction

    // A size write is only made once the block has gone quiet.
    task automatic write_size(input logic [SIZE_W-1:0] sz);
        s_tvalid <= 1'b0;
        while (max_sum_q.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
        cfg_data  <= sz;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        burst_left = 0;
        set_matrix_size(sz);
    endtask

    task automatic put_cell(input logic [15:0] v, input bit typed, input sum_t want);
        int   gap;
        int   r;
        sum_t res;
        if (burst_left == 0) begin
            r = $urandom_range(0, 9);
            gap = (r < 3) ? 0 : (r < 9) ? $urandom_range(1, 8) : $urandom_range(20, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        if (take_cell(cell_t'(v), res))
            max_sum_q.push_back(typed ? want : res);
    endtask

    // Receiver: random segments of steady, random and patterned back-pressure,
    // plus one long hold-off on request so that the block fills up.
    initial begin
        int mode;
        int len;
        int tick;
        tick = 0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(8, 64);
                repeat (len) begin
                    if (hold_req)
                        break;
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= (tick % 3 == 0);
                        default: m_tready <= ($urandom_range(0, 7) == 0);
                    endcase
                    tick++;
                    @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (max_sum_q.size() == 0) begin
                $display("%0t: max_sum expected none, got %0d", $time,
                         $signed(m_tdata[SUM_W-1:0]));
                fails++;
            end else if (m_tdata !== {{(OUT_DATA_W-SUM_W){1'b0}}, max_sum_q[0]}) begin
                $display("%0t: max_sum expected %0d, got %0d (m_tdata %h)", $time,
                         max_sum_q[0], $signed(m_tdata[SUM_W-1:0]), m_tdata);
                fails++;
                void'(max_sum_q.pop_front());
            end else begin
                void'(max_sum_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int               n_random;
        int               phase;
        int               r;
        int               n;
        int               matrices;
        int               total;
        logic [SIZE_W-1:0] sz;
        logic [15:0]      v;

        foreach (best_row[i])
            best_row[i] = '0;
        set_matrix_size(SIZE_W'(4));
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].op == OP_SIZE)
                write_size(script[i].arg[SIZE_W-1:0]);
            else
                put_cell(script[i].arg, script[i].typed, script[i].want);
        end

        n_random = 0;
        phase    = 0;
        while (n_random < 1450) begin
            r = $urandom_range(0, 99);
            if (phase == 0)
                sz = SIZE_W'(1);
            else if (r < 8)
                sz = '0;
            else if (r < 60)
                sz = SIZE_W'($urandom_range(1, 6));
            else if (r < 85)
                sz = SIZE_W'($urandom_range(7, 16));
            else if (r < 93)
                sz = SIZE_W'($urandom_range(17, 32));
            else
                sz = SIZE_W'($urandom_range(65, 127));
            n = (sz == 0) ? 1 : (sz > N_LIMIT) ? N_LIMIT : sz;
            matrices = (phase == 0) ? 60 : (n > 16) ? 1 : $urandom_range(1, 4);
            total = matrices * n * n;
            // Large sizes are only started, then abandoned by the next size write.
            if (sz > N_LIMIT)
                total = $urandom_range(1, 300);
            else if (n > 1 && $urandom_range(0, 5) == 0)
                total = (matrices - 1) * n * n + $urandom_range(1, n * n - 1);
            // The last run is cut short so that the item count stays near its target.
            if (n_random + total > 1450)
                total = 1450 - n_random;
            write_size(sz);
            if (phase == 0)
                hold_req = 1'b1;
            for (int k = 0; k < total; k++) begin
                r = $urandom_range(0, 15);
                if (r == 0)
                    v = 16'h7FFF;
                else if (r == 1)
                    v = 16'h8000;
                else if (r < 4)
                    v = 16'(int'($urandom_range(0, 6)) - 3);
                else
                    v = 16'($urandom);
                put_cell(v, 1'b0, '0);
                n_random++;
            end
            phase++;
        end

        // Full-scale cells at both extremes of the cell range.
        write_size(SIZE_W'(8));
        for (int k = 0; k < 8 * 8; k++)
            put_cell(16'h7FFF, k == 8 * 8 - 1, sum_t'(8 * 32767));
        write_size(SIZE_W'(8));
        for (int k = 0; k < 8 * 8; k++)
            put_cell(16'h8000, k == 8 * 8 - 1, sum_t'(-8 * 32768));

        s_tvalid <= 1'b0;
        while (max_sum_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/mdps_pkg.sv
src/mdps_row_mem.sv
src/mdps_update.sv
src/max_diagonal_path_sum.sv
tb/max_diagonal_path_sum_tb.sv
